// ----- src/msc_pkg.sv -----
// types, codes and helper functions shared by the material sorter files
package msc_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned MinW    = 11;
  localparam int unsigned TotalW  = 16;

  localparam logic [MinW-1:0]    MinReset        = 11'd1337;
  localparam logic [SampleW-1:0] AlumLimitReset  = 10'd255;
  localparam logic [SampleW-1:0] SteelLimitReset = 10'd750;
  localparam logic [SampleW-1:0] WhiteLimitReset = 10'd900;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_SAMPLE   = 3'd1,
    OP_MEASURED = 3'd2,
    OP_EXIT     = 3'd3,
    OP_HOMED    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_ALUM  = 2'd0,
    CFG_STEEL = 2'd1,
    CFG_WHITE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MAT_ALUM  = 2'd0,
    MAT_STEEL = 2'd1,
    MAT_WHITE = 2'd2,
    MAT_BLACK = 2'd3
  } material_e;

  // bins numbered clockwise
  typedef enum logic [1:0] {
    BIN_BLACK = 2'd0,
    BIN_ALUM  = 2'd1,
    BIN_WHITE = 2'd2,
    BIN_STEEL = 2'd3
  } bin_e;

  typedef enum logic [1:0] {
    AMT_NONE    = 2'd0,
    AMT_QUARTER = 2'd1,
    AMT_HALF    = 2'd2
  } amount_e;

  typedef enum logic {
    DIR_CW  = 1'b0,
    DIR_CCW = 1'b1
  } dir_e;

  typedef enum logic [1:0] {
    TURN_NONE    = 2'd0,
    TURN_QUARTER = 2'd1,
    TURN_HALF    = 2'd2,
    TURN_REVERSE = 2'd3
  } turn_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    material_e         material;
    amount_e           move_amount;
    dir_e              move_dir;
    turn_e             rotation_kind;
    status_e           status;
    logic [MinW-1:0]   current_min;
    logic [TotalW-1:0] steel_total;
    logic [TotalW-1:0] alum_total;
    logic [TotalW-1:0] plastic_total;
    logic [TotalW-1:0] sorted_total;
  } result_t;

  function automatic bin_e bin_of_class(input material_e mat);
    bin_e b;
    unique case (mat)
      MAT_ALUM:  b = BIN_ALUM;
      MAT_STEEL: b = BIN_STEEL;
      MAT_WHITE: b = BIN_WHITE;
      MAT_BLACK: b = BIN_BLACK;
      default:   b = BIN_BLACK;
    endcase
    return b;
  endfunction

  function automatic material_e classify(input logic [MinW-1:0] m,
                                         input logic [SampleW-1:0] alum_lim,
                                         input logic [SampleW-1:0] steel_lim,
                                         input logic [SampleW-1:0] white_lim);
    material_e r;
    priority if (m < {1'b0, alum_lim}) begin
      r = MAT_ALUM;
    end else if (m < {1'b0, steel_lim}) begin
      r = MAT_STEEL;
    end else if (m < {1'b0, white_lim}) begin
      r = MAT_WHITE;
    end else begin
      r = MAT_BLACK;
    end
    return r;
  endfunction

endpackage

// ----- src/msc_ram.sv -----
// generic single-write, single-read ram with registered read data
module msc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/material_sort_controller_top.sv -----
// material sorter core: minimum tracking, classification, class queue and disk moves
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | sink      | in_valid_i/in_stall_o  | opcode_i, sample_i
//   out     | source    | out_valid_o/out_stall_i| material_o .. sorted_total_o, queue_count_o
//   cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// one transaction per cycle while out_stall_i is low; each result is registered
// the class queue sits in a ram read at the next head pointer, so the head is ready
// when an exit transaction arrives; a push into the head slot is forwarded
// no clearing pass after reset: queue entries are only read after being written
// a result register plus one skid entry decouple the sides; in_stall_o rises only
// when both are full
module material_sort_controller_top
  import msc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [SampleW-1:0]                cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        opcode_i,
  input  logic [SampleW-1:0]                sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        material_o,
  output logic [1:0]                        move_amount_o,
  output logic                              move_dir_o,
  output logic [1:0]                        rotation_kind_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   queue_count_o,
  output logic [1:0]                        status_o,
  output logic [MinW-1:0]                   current_min_o,
  output logic [TotalW-1:0]                 steel_total_o,
  output logic [TotalW-1:0]                 alum_total_o,
  output logic [TotalW-1:0]                 plastic_total_o,
  output logic [TotalW-1:0]                 sorted_total_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  // configuration
  logic [SampleW-1:0] alum_lim_q, steel_lim_q, white_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alum_lim_q  <= AlumLimitReset;
      steel_lim_q <= SteelLimitReset;
      white_lim_q <= WhiteLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALUM:  alum_lim_q  <= cfg_data_i;
        CFG_STEEL: steel_lim_q <= cfg_data_i;
        CFG_WHITE: white_lim_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // core state
  logic [MinW-1:0]   min_q, min_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  bin_e              bin_q, bin_d;
  dir_e              last_dir_q, last_dir_d;
  logic [TotalW-1:0] steel_cnt_q, steel_cnt_d, alum_cnt_q, alum_cnt_d;
  logic [TotalW-1:0] plastic_cnt_q, plastic_cnt_d, sorted_cnt_q, sorted_cnt_d;
  logic              fwd_q, fwd_d;
  material_e         fwd_data_q;

  logic              accept;
  logic              ram_we;
  logic [1:0]        ram_rdata;
  material_e         head;
  material_e         cls;
  bin_e              target;
  logic [1:0]        delta;
  dir_e              new_dir;
  result_t           res;

  assign accept = in_valid_i && !in_stall_o;
  assign head   = fwd_q ? fwd_data_q : material_e'(ram_rdata);
  assign cls    = classify(min_q, alum_lim_q, steel_lim_q, white_lim_q);
  assign target = bin_of_class(head);
  assign delta  = target - bin_q;
  assign new_dir = (delta == 2'd1) ? DIR_CW : DIR_CCW;

  always_comb begin
    min_d         = min_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    fill_d        = fill_q;
    bin_d         = bin_q;
    last_dir_d    = last_dir_q;
    steel_cnt_d   = steel_cnt_q;
    alum_cnt_d    = alum_cnt_q;
    plastic_cnt_d = plastic_cnt_q;
    sorted_cnt_d  = sorted_cnt_q;
    ram_we        = 1'b0;
    res.material      = MAT_ALUM;
    res.move_amount   = AMT_NONE;
    res.move_dir      = DIR_CW;
    res.rotation_kind = TURN_NONE;
    res.status        = ST_OK;
    if (accept) begin
      unique case (op_e'(opcode_i))
        OP_START: begin
          min_d = MinReset;
        end
        OP_SAMPLE: begin
          if ({1'b0, sample_i} < min_q) begin
            min_d = {1'b0, sample_i};
          end
        end
        OP_MEASURED: begin
          res.material = cls;
          if (fill_q == CntFull) begin
            res.status = ST_FULL;
          end else begin
            ram_we   = 1'b1;
            wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
            fill_d   = fill_q + 1'b1;
          end
        end
        OP_EXIT: begin
          if (fill_q == '0) begin
            res.status = ST_EMPTY;
          end else begin
            res.material = head;
            rd_ptr_d     = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
            fill_d       = fill_q - 1'b1;
            unique case (head)
              MAT_ALUM:  alum_cnt_d    = alum_cnt_q + 1'b1;
              MAT_STEEL: steel_cnt_d   = steel_cnt_q + 1'b1;
              default:   plastic_cnt_d = plastic_cnt_q + 1'b1;
            endcase
            sorted_cnt_d = sorted_cnt_q + 1'b1;
            unique case (delta)
              2'd1, 2'd3: begin
                res.move_amount   = AMT_QUARTER;
                res.move_dir      = new_dir;
                res.rotation_kind = (new_dir != last_dir_q) ? TURN_REVERSE : TURN_QUARTER;
                last_dir_d        = new_dir;
              end
              2'd2: begin
                res.move_amount   = AMT_HALF;
                res.move_dir      = last_dir_q;
                res.rotation_kind = TURN_HALF;
              end
              default: ;
            endcase
            bin_d = target;
          end
        end
        OP_HOMED: begin
          bin_d = BIN_BLACK;
        end
        default: ;
      endcase
    end
    res.current_min   = min_d;
    res.steel_total   = steel_cnt_d;
    res.alum_total    = alum_cnt_d;
    res.plastic_total = plastic_cnt_d;
    res.sorted_total  = sorted_cnt_d;
  end

  // forward a push into the slot being read this cycle
  assign fwd_d = ram_we && (wr_ptr_q == rd_ptr_d);

  msc_ram #(
    .WIDTH(2),
    .DEPTH(FIFO_DEPTH)
  ) u_class_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(cls),
    .raddr_i(rd_ptr_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q         <= MinReset;
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      fill_q        <= '0;
      bin_q         <= BIN_BLACK;
      last_dir_q    <= DIR_CW;
      steel_cnt_q   <= '0;
      alum_cnt_q    <= '0;
      plastic_cnt_q <= '0;
      sorted_cnt_q  <= '0;
      fwd_q         <= 1'b0;
    end else begin
      min_q         <= min_d;
      rd_ptr_q      <= rd_ptr_d;
      wr_ptr_q      <= wr_ptr_d;
      fill_q        <= fill_d;
      bin_q         <= bin_d;
      last_dir_q    <= last_dir_d;
      steel_cnt_q   <= steel_cnt_d;
      alum_cnt_q    <= alum_cnt_d;
      plastic_cnt_q <= plastic_cnt_d;
      sorted_cnt_q  <= sorted_cnt_d;
      fwd_q         <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= cls;
  end

  // result register and skid entry
  result_t         out_q, skid_q;
  logic [CntW-1:0] out_cnt_q, skid_cnt_q;
  logic            out_valid_q, skid_valid_q;
  logic            out_ready;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= skid_valid_q && accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q     <= skid_q;
        out_cnt_q <= skid_cnt_q;
        if (accept) begin
          skid_q     <= res;
          skid_cnt_q <= fill_d;
        end
      end else if (accept) begin
        out_q     <= res;
        out_cnt_q <= fill_d;
      end
    end else if (accept) begin
      skid_q     <= res;
      skid_cnt_q <= fill_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign material_o      = out_q.material;
  assign move_amount_o   = out_q.move_amount;
  assign move_dir_o      = out_q.move_dir;
  assign rotation_kind_o = out_q.rotation_kind;
  assign queue_count_o   = out_cnt_q;
  assign status_o        = out_q.status;
  assign current_min_o   = out_q.current_min;
  assign steel_total_o   = out_q.steel_total;
  assign alum_total_o    = out_q.alum_total;
  assign plastic_total_o = out_q.plastic_total;
  assign sorted_total_o  = out_q.sorted_total;

endmodule

// ----- tb/sv/material_sort_checker.sv -----
// checker for the material sorter: watches the in, out and cfg channels, predicts each result and compares
`timescale 1ns / 100ps
module material_sort_checker
  import msc_pkg::*;
#(
  parameter int unsigned FifoDepth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [SampleW-1:0]                cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [2:0]                        opcode_i,
  input  logic [SampleW-1:0]                sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [1:0]                        material_i,
  input  logic [1:0]                        move_amount_i,
  input  logic                              move_dir_i,
  input  logic [1:0]                        rotation_kind_i,
  input  logic [$clog2(FifoDepth+1)-1:0]    queue_count_i,
  input  logic [1:0]                        status_i,
  input  logic [MinW-1:0]                   current_min_i,
  input  logic [TotalW-1:0]                 steel_total_i,
  input  logic [TotalW-1:0]                 alum_total_i,
  input  logic [TotalW-1:0]                 plastic_total_i,
  input  logic [TotalW-1:0]                 sorted_total_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  localparam int unsigned CountW = $clog2(FifoDepth + 1);

  typedef struct packed {
    material_e         material;
    amount_e           amount;
    dir_e              dir;
    turn_e             turn;
    logic [CountW-1:0] fill;
    status_e           status;
    logic [MinW-1:0]   cur_min;
    logic [TotalW-1:0] steel;
    logic [TotalW-1:0] alum;
    logic [TotalW-1:0] plastic;
    logic [TotalW-1:0] sorted;
  } sort_result_t;

  logic [SampleW-1:0] alum_lim, steel_lim, white_lim;
  logic [MinW-1:0]    min_q;
  material_e          class_store [FifoDepth];
  int unsigned        rd_q, wr_q, fill_q;
  bin_e               bin_q;
  dir_e               last_dir_q;
  logic [TotalW-1:0]  steel_q, alum_q, plastic_q, sorted_q;
  sort_result_t       pending_results[$];
  sort_result_t       want;
  int unsigned        fails;

  function automatic material_e grade_reading(input logic [MinW-1:0] m);
    if (m < {1'b0, alum_lim}) return MAT_ALUM;
    if (m < {1'b0, steel_lim}) return MAT_STEEL;
    if (m < {1'b0, white_lim}) return MAT_WHITE;
    return MAT_BLACK;
  endfunction

  function automatic bin_e bin_for(input material_e mat);
    case (mat)
      MAT_ALUM:  return BIN_ALUM;
      MAT_STEEL: return BIN_STEEL;
      MAT_WHITE: return BIN_WHITE;
      default:   return BIN_BLACK;
    endcase
  endfunction

  function automatic sort_result_t advance_sorter(input logic [2:0] op,
                                                  input logic [SampleW-1:0] smp);
    sort_result_t r;
    bin_e         target;
    logic [1:0]   delta;
    dir_e         turn_dir;
    r = '0;
    case (op)
      OP_START: min_q = MinReset;
      OP_SAMPLE: begin
        if ({1'b0, smp} < min_q) min_q = {1'b0, smp};
      end
      OP_MEASURED: begin
        r.material = grade_reading(min_q);
        if (fill_q >= FifoDepth) begin
          r.status = ST_FULL;
        end else begin
          class_store[wr_q] = r.material;
          wr_q = (wr_q + 1) % FifoDepth;
          fill_q++;
        end
      end
      OP_EXIT: begin
        if (fill_q == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.material = class_store[rd_q];
          rd_q = (rd_q + 1) % FifoDepth;
          fill_q--;
          case (r.material)
            MAT_ALUM:  alum_q = alum_q + 1'b1;
            MAT_STEEL: steel_q = steel_q + 1'b1;
            default:   plastic_q = plastic_q + 1'b1;
          endcase
          sorted_q = sorted_q + 1'b1;
          target = bin_for(r.material);
          delta = 2'(target) - 2'(bin_q);
          if (delta[0]) begin
            // one bin either way: quarter turn, possibly reversing
            turn_dir = (delta == 2'd1) ? DIR_CW : DIR_CCW;
            r.amount = AMT_QUARTER;
            r.dir = turn_dir;
            r.turn = (turn_dir != last_dir_q) ? TURN_REVERSE : TURN_QUARTER;
            last_dir_q = turn_dir;
          end else if (delta == 2'd2) begin
            r.amount = AMT_HALF;
            r.dir = last_dir_q;
            r.turn = TURN_HALF;
          end
          bin_q = target;
        end
      end
      OP_HOMED: bin_q = BIN_BLACK;
      default: ;
    endcase
    r.fill = CountW'(fill_q);
    r.cur_min = min_q;
    r.steel = steel_q;
    r.alum = alum_q;
    r.plastic = plastic_q;
    r.sorted = sorted_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [TotalW-1:0] exp_v,
                                      input logic [TotalW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alum_lim = AlumLimitReset;
      steel_lim = SteelLimitReset;
      white_lim = WhiteLimitReset;
      min_q = MinReset;
      rd_q = 0;
      wr_q = 0;
      fill_q = 0;
      bin_q = BIN_BLACK;
      last_dir_q = DIR_CW;
      steel_q = '0;
      alum_q = '0;
      plastic_q = '0;
      sorted_q = '0;
      fails = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("material", want.material, material_i);
          check_field("move_amount", want.amount, move_amount_i);
          check_field("move_dir", want.dir, move_dir_i);
          check_field("rotation_kind", want.turn, rotation_kind_i);
          check_field("queue_count", want.fill, queue_count_i);
          check_field("status", want.status, status_i);
          check_field("current_min", want.cur_min, current_min_i);
          check_field("steel_total", want.steel, steel_total_i);
          check_field("alum_total", want.alum, alum_total_i);
          check_field("plastic_total", want.plastic, plastic_total_i);
          check_field("sorted_total", want.sorted, sorted_total_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(advance_sorter(opcode_i, sample_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ALUM:  alum_lim = cfg_data_i;
          CFG_STEEL: steel_lim = cfg_data_i;
          CFG_WHITE: white_lim = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= pending_results.size();
    end
  end

endmodule

// ----- tb/sv/material_sort_controller_top_test.sv -----
// testbench top for the material sorter: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module material_sort_controller_top_test;
  import msc_pkg::*;

  localparam int unsigned FifoDepth   = 16;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PhaseItems  = 290;
  localparam int unsigned CycleLimit  = 200000;
  localparam logic [2:0]  OpSpareFirst = 3'(OP_HOMED) + 3'd1;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [1:0]                       cfg_index_i;
  logic [SampleW-1:0]               cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [2:0]                       opcode_i;
  logic [SampleW-1:0]               sample_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic [1:0]                       material_o;
  logic [1:0]                       move_amount_o;
  logic                             move_dir_o;
  logic [1:0]                       rotation_kind_o;
  logic [$clog2(FifoDepth+1)-1:0]   queue_count_o;
  logic [1:0]                       status_o;
  logic [MinW-1:0]                  current_min_o;
  logic [TotalW-1:0]                steel_total_o;
  logic [TotalW-1:0]                alum_total_o;
  logic [TotalW-1:0]                plastic_total_o;
  logic [TotalW-1:0]                sorted_total_o;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycles = 0;
  int unsigned        sent;
  logic               idle_en;
  logic               hold_req;
  logic [SampleW-1:0] alum_lim, steel_lim, white_lim;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  material_sort_controller_top #(
    .FIFO_DEPTH(FifoDepth)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .sample_i,
    .out_valid_o, .out_stall_i, .material_o, .move_amount_o, .move_dir_o,
    .rotation_kind_o, .queue_count_o, .status_o, .current_min_o,
    .steel_total_o, .alum_total_o, .plastic_total_o, .sorted_total_o
  );

  material_sort_checker #(
    .FifoDepth(FifoDepth)
  ) checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .material_i(material_o), .move_amount_i(move_amount_o), .move_dir_i(move_dir_o),
    .rotation_kind_i(rotation_kind_o), .queue_count_i(queue_count_o), .status_i(status_o),
    .current_min_i(current_min_o), .steel_total_i(steel_total_o),
    .alum_total_i(alum_total_o), .plastic_total_i(plastic_total_o),
    .sorted_total_i(sorted_total_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic offer(input logic [2:0] op, input logic [SampleW-1:0] smp);
    if (idle_en && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [SampleW-1:0] a, input logic [SampleW-1:0] s,
                            input logic [SampleW-1:0] w);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ALUM;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_index_i <= CFG_STEEL;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_index_i <= CFG_WHITE;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alum_lim = a;
    steel_lim = s;
    white_lim = w;
  endtask

  // readings cluster around the thresholds half of the time
  function automatic logic [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] lim;
    case ($urandom_range(0, 5))
      0: lim = alum_lim;
      1: lim = steel_lim;
      2: lim = white_lim;
      default: return SampleW'($urandom);
    endcase
    return lim + SampleW'($urandom_range(0, 4)) - SampleW'(2);
  endfunction

  task automatic sort_batch(input int unsigned exit_max);
    offer(OP_START, SampleW'($urandom));
    repeat ($urandom_range(0, 4)) offer(OP_SAMPLE, pick_sample());
    offer(OP_MEASURED, SampleW'($urandom));
    repeat ($urandom_range(0, exit_max)) offer(OP_EXIT, SampleW'($urandom));
  endtask

  task automatic run_phase(input int unsigned exit_max);
    int unsigned stop;
    stop = sent + PhaseItems;
    while (sent < stop) begin
      if ($urandom_range(0, 99) < 80) begin
        sort_batch(exit_max);
      end else begin
        offer(3'($urandom_range(0, 7)), SampleW'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned a, s, w;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_ALUM;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OP_START;
    sample_i <= '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    sent = 0;
    alum_lim = AlumLimitReset;
    steel_lim = SteelLimitReset;
    white_lim = WhiteLimitReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds; empty exit, homing, spare opcodes
    offer(OP_EXIT, '1);
    offer(OP_HOMED, '0);
    for (int k = 0; k < 3; k++) offer(OpSpareFirst + 3'(k), SampleW'($urandom));
    // one item of each class, then two classifications without a fresh start
    offer(OP_START, '1);
    offer(OP_SAMPLE, '1);
    offer(OP_SAMPLE, '0);
    offer(OP_MEASURED, '1);
    offer(OP_START, '0);
    offer(OP_SAMPLE, SampleW'(500));
    offer(OP_MEASURED, '0);
    offer(OP_START, '0);
    offer(OP_SAMPLE, SampleW'(800));
    offer(OP_MEASURED, '0);
    offer(OP_START, '0);
    offer(OP_MEASURED, '0);
    offer(OP_SAMPLE, AlumLimitReset - SampleW'(1));
    offer(OP_MEASURED, '0);
    offer(OP_MEASURED, '1);
    // quarter, half, reversing quarter, half back, reversing quarter, no move
    repeat (6) offer(OP_EXIT, SampleW'($urandom));
    offer(OP_HOMED, '1);
    drain();

    set_limits('0, '0, '0);
    run_phase(1);

    set_limits('1, '1, '1);
    hold_req = 1'b1;
    run_phase(3);

    a = $urandom_range(0, 1023);
    s = $urandom_range(a, 1023);
    w = $urandom_range(s, 1023);
    set_limits(SampleW'(a), SampleW'(s), SampleW'(w));
    run_phase(2);

    set_limits(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom));
    run_phase(1);

    set_limits(SampleW'(100), SampleW'(400), SampleW'(700));
    run_phase(3);

    idle_en = 1'b0;
    set_limits(AlumLimitReset, SteelLimitReset, WhiteLimitReset);
    run_phase(2);

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
